### hdl/cwvf_pkg.sv
// Shared types and constants for the classifier window vote filter.
package cwvf_pkg;

   // Field widths of the input and result items.
   localparam int CODE_W  = 5;
   localparam int TIME_W  = 32;
   localparam int LIMIT_W = 16;
   localparam int VOTE_W  = 4;
   localparam int DIGIT_W = 4;

   // Packed stream and register port widths.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Bit positions inside the request beat.
   localparam int REQ_CODE_LSB = 0;
   localparam int REQ_NOW_LSB  = REQ_CODE_LSB + CODE_W;

   // Default sizing of the vote window.
   localparam int DEF_WINDOW_LEN  = 8;
   localparam int DEF_CLASS_COUNT = 10;

   // Special class codes and entry markers.
   localparam logic [CODE_W-1:0]  CODE_READ_FAILED = CODE_W'(-2);
   localparam logic [CODE_W-1:0]  CODE_CONTROL     = CODE_W'(10);
   localparam logic [DIGIT_W-1:0] EMPTY_ENTRY      = 4'hF;
   localparam logic [DIGIT_W-1:0] NONE_EMITTED     = 4'hF;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_MIN_VOTES  = 2'd0;
   localparam logic [1:0] REG_SHORT_HOLD = 2'd1;
   localparam logic [1:0] REG_LONG_HOLD  = 2'd2;

   // Register reset values.
   localparam logic [VOTE_W-1:0]  RST_MIN_VOTES  = 4'd2;
   localparam logic [LIMIT_W-1:0] RST_SHORT_HOLD = 16'd1000;
   localparam logic [LIMIT_W-1:0] RST_LONG_HOLD  = 16'd3000;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIN_READ,
      ST_DEC_READ,
      ST_INC_READ,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

### hdl/classifier_window_vote_filter.sv
// Sliding-window majority vote over classifier results with a control hold timer.
//
// Input beats on req_* carry one classifier result and its millisecond timestamp.
// Every accepted beat yields exactly one result beat on rsp_*, in order.
// A failed read or a control symbol yields an all-zero result; any other code
// closes a running hold (backspace or long_hold) and enters the vote window.
// The window entries and the per-class counts live in two small synchronous
// memories with registered reads; each counted item reads the replaced window
// slot, does a read-modify-write of the leaving class count and of the entering
// class count where each is a real class, then scans all CLASS_COUNT counts.
// A failed read or a control symbol skips the memories and goes straight to
// the result. The count memory is scanned one entry per cycle.
// The result sits in an output register, so the next beat is taken while a
// finished result still waits; a stalled receiver holds rsp_tdata steady and
// blocks the block only when a second result is ready to leave.
// Reset (synchronous, active high) empties the window and zeroes the counts
// through per-entry valid bits, so no clearing pass over the memories is needed.
// Registers: min_votes at 0x0, short_hold_min_ms at 0x4, long_hold_ms at 0x8.
module classifier_window_vote_filter #(
   parameter int WINDOW_LEN  = cwvf_pkg::DEF_WINDOW_LEN,
   parameter int CLASS_COUNT = cwvf_pkg::DEF_CLASS_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request beats.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] class_code, [36:5] now_ms, [39:37] zero
   input  logic [cwvf_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Result beats.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] digit_valid, [4:1] digit, [5] backspace, [6] long_hold, [7] zero
   output logic [cwvf_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cwvf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cwvf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cwvf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import cwvf_pkg::*;

   localparam int PosW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int ClsIdxW = $clog2(CLASS_COUNT);
   localparam int CntW    = $clog2(WINDOW_LEN + 1);
   localparam int CmpW    = (CntW > VOTE_W) ? CntW : VOTE_W;
   localparam logic [PosW-1:0]    PosLast    = PosW'(WINDOW_LEN - 1);
   localparam logic [ClsIdxW-1:0] ClsIdxLast = ClsIdxW'(CLASS_COUNT - 1);
   localparam logic [DIGIT_W-1:0] ClsLast    = DIGIT_W'(CLASS_COUNT - 1);
   localparam logic [CntW-1:0]    CntMax     = CntW'(WINDOW_LEN);

   // Configuration registers.
   logic [VOTE_W-1:0]  min_votes_ff;
   logic [LIMIT_W-1:0] short_hold_ff;
   logic [LIMIT_W-1:0] long_hold_ff;
   logic               csr_wr;

   // Sequencer.
   state_type state_ff, state_in;

   // Window memory and its read port.
   logic [DIGIT_W-1:0] win_mem [WINDOW_LEN];
   logic [WINDOW_LEN-1:0] win_vld_ff;
   logic [DIGIT_W-1:0] win_rd_ff;
   logic [PosW-1:0]    pos_ff;
   logic               win_we;

   // Count memory and its read port.
   logic [CntW-1:0]    cnt_mem [CLASS_COUNT];
   logic [CLASS_COUNT-1:0] cnt_vld_ff;
   logic [CntW-1:0]    cnt_rd_ff;
   logic               cnt_rvld_ff;
   logic [ClsIdxW-1:0] cnt_raddr;
   logic [ClsIdxW-1:0] cnt_waddr;
   logic [CntW-1:0]    cnt_wdata;
   logic               cnt_we;
   logic [CntW-1:0]    cnt_val;
   logic [CntW-1:0]    cnt_dec;

   // Per-item working registers.
   logic [DIGIT_W-1:0] entry_ff;
   logic [ClsIdxW-1:0] old_ff;
   logic               same_ff;
   logic [CntW-1:0]    dec_val_ff;
   logic [TIME_W-1:0]  dur_ff;
   logic               bs_ff;
   logic               lh_ff;
   logic               res_dv_ff;
   logic [DIGIT_W-1:0] res_dg_ff;
   logic [DIGIT_W-1:0] last_ff;

   // Hold timer.
   logic               hold_active_ff;
   logic [TIME_W-1:0]  hold_start_ff;

   // Count scan.
   logic [ClsIdxW-1:0] scan_addr_ff;
   logic               scan_issued_ff;
   logic               scan_live_ff;
   logic [ClsIdxW-1:0] scan_ridx_ff;
   logic [ClsIdxW-1:0] best_idx_ff;
   logic [CntW-1:0]    best_cnt_ff;
   logic               scan_take;
   logic [ClsIdxW-1:0] fin_idx;
   logic [CntW-1:0]    fin_cnt;
   logic               scan_last;
   logic               fin_dv;

   // Output register.
   logic               rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic               rsp_load;

   // Request decode.
   logic signed [CODE_W-1:0] req_code;
   logic [TIME_W-1:0]  req_now;
   logic               req_fire;
   logic               code_fail;
   logic               code_ctrl;
   logic               code_cls;

   // Window read decode.
   logic [DIGIT_W-1:0] old_entry;
   logic               old_is_cls;
   logic               entry_is_cls;
   logic               flag_bs;
   logic               flag_lh;

   assign req_code  = req_tdata[REQ_CODE_LSB +: CODE_W];
   assign req_now   = req_tdata[REQ_NOW_LSB +: TIME_W];
   assign req_fire  = req_tvalid && req_tready;
   assign code_fail = (req_code == CODE_READ_FAILED);
   assign code_ctrl = (req_code == CODE_CONTROL);
   assign code_cls  = !req_code[CODE_W-1] && (req_code[DIGIT_W-1:0] <= ClsLast);

   // Configuration port: writes on the access phase, reads return the register.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_votes_ff  <= RST_MIN_VOTES;
         short_hold_ff <= RST_SHORT_HOLD;
         long_hold_ff  <= RST_LONG_HOLD;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_MIN_VOTES:  min_votes_ff  <= csr_pwdata[VOTE_W-1:0];
            REG_SHORT_HOLD: short_hold_ff <= csr_pwdata[LIMIT_W-1:0];
            REG_LONG_HOLD:  long_hold_ff  <= csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MIN_VOTES:  csr_prdata = CSR_DATA_W'(min_votes_ff);
         REG_SHORT_HOLD: csr_prdata = CSR_DATA_W'(short_hold_ff);
         REG_LONG_HOLD:  csr_prdata = CSR_DATA_W'(long_hold_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Values read back from the memories; an entry never written reads as reset.
   assign old_entry    = win_vld_ff[pos_ff] ? win_rd_ff : EMPTY_ENTRY;
   assign old_is_cls   = (old_entry <= ClsLast);
   assign entry_is_cls = (entry_ff <= ClsLast);
   assign cnt_val      = cnt_rvld_ff ? cnt_rd_ff : '0;
   assign cnt_dec      = (cnt_val != '0) ? cnt_val - 1'b1 : '0;

   // Hold limits compared against the duration taken at acceptance.
   always_comb begin
      flag_bs = 1'b0;
      flag_lh = 1'b0;
      if ((dur_ff > TIME_W'(short_hold_ff)) && (dur_ff < TIME_W'(long_hold_ff))) begin
         flag_bs = 1'b1;
      end else if (dur_ff > TIME_W'(long_hold_ff)) begin
         flag_lh = 1'b1;
      end
   end

   // Scan compare: first count seeds the best, later ones replace it only if larger.
   assign scan_take = (scan_ridx_ff == '0) || (cnt_val > best_cnt_ff);
   assign fin_idx   = scan_take ? scan_ridx_ff : best_idx_ff;
   assign fin_cnt   = scan_take ? cnt_val : best_cnt_ff;
   assign scan_last = scan_live_ff && (scan_ridx_ff == ClsIdxLast);
   assign fin_dv    = (CmpW'(fin_cnt) > CmpW'(min_votes_ff))
                      && (DIGIT_W'(fin_idx) != last_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (code_fail || code_ctrl) ? ST_RESULT : ST_WIN_READ;
            end
         end
         ST_WIN_READ: begin
            if (old_is_cls) begin
               state_in = ST_DEC_READ;
            end else if (entry_is_cls) begin
               state_in = ST_INC_READ;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DEC_READ: state_in = entry_is_cls ? ST_INC_READ : ST_SCAN;
         ST_INC_READ: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, memory strobes and addresses.
   always_comb begin
      req_tready = 1'b0;
      win_we     = 1'b0;
      cnt_we     = 1'b0;
      cnt_waddr  = old_ff;
      cnt_wdata  = cnt_dec;
      cnt_raddr  = scan_addr_ff;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_WIN_READ: begin
            win_we    = 1'b1;
            cnt_raddr = old_is_cls ? old_entry[ClsIdxW-1:0] : entry_ff[ClsIdxW-1:0];
         end
         ST_DEC_READ: begin
            cnt_we    = 1'b1;
            cnt_raddr = entry_ff[ClsIdxW-1:0];
         end
         ST_INC_READ: begin
            cnt_we    = 1'b1;
            cnt_waddr = entry_ff[ClsIdxW-1:0];
            cnt_wdata = (same_ff ? dec_val_ff : cnt_val) + 1'b1;
         end
         ST_SCAN: cnt_raddr = scan_addr_ff;
         ST_RESULT: rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // Window memory: one write and one registered read at the current slot.
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[pos_ff] <= entry_ff;
      end
      win_rd_ff <= win_mem[pos_ff];
   end

   // Count memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // Control state, valid bits and per-item registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pos_ff         <= '0;
         win_vld_ff     <= '0;
         cnt_vld_ff     <= '0;
         cnt_rvld_ff    <= 1'b0;
         last_ff        <= NONE_EMITTED;
         hold_active_ff <= 1'b0;
         hold_start_ff  <= '0;
         scan_addr_ff   <= '0;
         scan_issued_ff <= 1'b0;
         scan_live_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_rvld_ff <= cnt_vld_ff[cnt_raddr];

         // Hold timer and duration capture at acceptance.
         if (state_ff == ST_IDLE && req_fire && !code_fail) begin
            if (code_ctrl) begin
               if (!hold_active_ff) begin
                  hold_active_ff <= 1'b1;
                  hold_start_ff  <= req_now;
               end
            end else begin
               hold_active_ff <= 1'b0;
            end
         end

         // Slot replacement advances the circular position.
         if (win_we) begin
            win_vld_ff[pos_ff] <= 1'b1;
            pos_ff <= (pos_ff == PosLast) ? '0 : pos_ff + 1'b1;
         end
         if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end

         // Scan issues one count read per cycle; the data follows in the next cycle.
         if (state_ff == ST_SCAN) begin
            scan_live_ff <= !scan_issued_ff;
            if (!scan_issued_ff) begin
               if (scan_addr_ff == ClsIdxLast) begin
                  scan_issued_ff <= 1'b1;
               end else begin
                  scan_addr_ff <= scan_addr_ff + 1'b1;
               end
            end
         end else begin
            scan_addr_ff   <= '0;
            scan_issued_ff <= 1'b0;
            scan_live_ff   <= 1'b0;
         end

         if (scan_last && fin_dv) begin
            last_ff <= DIGIT_W'(fin_idx);
         end

         // Output register keeps its beat until the receiver takes it.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_fire) begin
         entry_ff  <= code_cls ? req_code[DIGIT_W-1:0] : EMPTY_ENTRY;
         dur_ff    <= hold_active_ff ? (req_now - hold_start_ff) : '0;
         bs_ff     <= 1'b0;
         lh_ff     <= 1'b0;
         res_dv_ff <= 1'b0;
         res_dg_ff <= '0;
      end
      if (state_ff == ST_WIN_READ) begin
         old_ff  <= old_entry[ClsIdxW-1:0];
         same_ff <= old_is_cls && (old_entry == entry_ff);
         bs_ff   <= flag_bs;
         lh_ff   <= flag_lh;
      end
      if (state_ff == ST_DEC_READ) begin
         dec_val_ff <= cnt_dec;
      end
      // The index of the count in flight is the read address, registered.
      if (state_ff == ST_SCAN) begin
         scan_ridx_ff <= scan_addr_ff;
      end
      if (scan_live_ff) begin
         best_idx_ff <= fin_idx;
         best_cnt_ff <= fin_cnt;
      end
      if (scan_last) begin
         res_dv_ff <= fin_dv;
         res_dg_ff <= fin_dv ? DIGIT_W'(fin_idx) : '0;
      end
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, lh_ff, bs_ff, res_dg_ff, res_dv_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A failed read skips all memory work and goes straight to the result.
   a_fail_direct: assert property (@(posedge clock) disable iff (reset)
      (req_fire && code_fail) |=> (state_ff == ST_RESULT))
      else $error("failed read did not go straight to the result");

   // A written count never exceeds the window length.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (cnt_wdata <= CntMax))
      else $error("class count exceeds window length");

   // An emitted digit is a real class index.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> (rsp_data_ff[4:1] <= ClsLast))
      else $error("emitted digit out of class range");

   // Backspace and long hold never come together.
   a_hold_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[5] && rsp_data_ff[6]))
      else $error("backspace and long hold raised together");

endmodule

### tb/classifier_window_vote_filter_tb.sv
// Self-checking testbench for the classifier window vote filter.
module classifier_window_vote_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cwvf_pkg::*;

   localparam int WIN_N          = DEF_WINDOW_LEN;
   localparam int CLASS_N        = DEF_CLASS_COUNT;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_BEATS    = 200;
   localparam int PHASE_N        = 6;
   localparam int HOLD_OFF_LEN   = 400;

   // Classifier result meaning "no class".
   localparam logic [CODE_W-1:0] CODE_NO_CLASS = CODE_W'(-1);

   // Result beat layout, lowest bit last in the list.
   typedef struct packed {
      logic               pad;
      logic               long_hold;
      logic               backspace;
      logic [DIGIT_W-1:0] digit;
      logic               digit_valid;
   } rsp_type;

   // One row of the directed part; want is used only when typed is set.
   typedef struct {
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] now_ms;
      bit                typed;
      rsp_type           want;
   } stim_row_type;

   // Register setting and idle pattern for one random phase.
   typedef struct {
      logic [VOTE_W-1:0]  min_votes;
      logic [LIMIT_W-1:0] short_hold;
      logic [LIMIT_W-1:0] long_hold;
      int                 gap_pct;
      int                 stall_pct;
      bit                 hold_off;
   } phase_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   classifier_window_vote_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the register file.
   logic [VOTE_W-1:0]  cfg_min_votes  = RST_MIN_VOTES;
   logic [LIMIT_W-1:0] cfg_short_hold = RST_SHORT_HOLD;
   logic [LIMIT_W-1:0] cfg_long_hold  = RST_LONG_HOLD;

   // Mirror of the vote window and the hold timer.
   logic [DIGIT_W-1:0] win_slots [WIN_N];
   logic [VOTE_W-1:0]  class_votes [CLASS_N];
   int                 win_pos      = 0;
   logic [DIGIT_W-1:0] last_digit   = NONE_EMITTED;
   bit                 hold_running = 1'b0;
   logic [TIME_W-1:0]  hold_t0      = '0;

   rsp_type results_due [$];

   int send_gap_pct    = 0;
   int rsp_stall_pct   = 0;
   int hold_off_cycles = 0;
   int quiet_cycles    = 0;
   int mismatch_count  = 0;
   int beats_sent      = 0;
   int counted_beats   = 0;
   int results_seen    = 0;
   int digits_seen     = 0;
   int backspaces_seen = 0;
   int long_holds_seen = 0;
   int settings_used   = 1;
   logic [TIME_W-1:0] now_q = '0;

   // Directed rows: special codes, hold limits, time wrap, votes and ties.
   stim_row_type directed_rows [25] = '{
      '{CODE_READ_FAILED, 32'd0,          1'b1, 8'h00},
      '{CODE_CONTROL,     32'd100,        1'b1, 8'h00},
      '{CODE_CONTROL,     32'hFFFF_FFFF,  1'b1, 8'h00}, // hold already running
      '{5'd3,             32'd1600,       1'b1, 8'h20}, // backspace
      '{5'd3,             32'd1700,       1'b1, 8'h00},
      '{5'd3,             32'd1800,       1'b1, 8'h07}, // digit 3
      '{CODE_CONTROL,     32'd4000,       1'b1, 8'h00},
      '{CODE_NO_CLASS,    32'd7000,       1'b1, 8'h00}, // exactly the long limit
      '{CODE_CONTROL,     32'd8000,       1'b1, 8'h00},
      '{5'd15,            32'd11001,      1'b1, 8'h40}, // long hold, unknown code
      '{CODE_CONTROL,     32'hFFFF_FC00,  1'b1, 8'h00},
      '{5'd0,             32'h0000_0200,  1'b1, 8'h20}, // backspace across the wrap
      '{CODE_CONTROL,     32'd20000,      1'b1, 8'h00},
      '{5'd9,             32'd21000,      1'b1, 8'h00}, // exactly the short limit
      '{CODE_W'(-16),     32'd21100,      1'b1, 8'h00},
      '{CODE_W'(-3),      32'd21200,      1'b1, 8'h00},
      '{5'd11,            32'd21300,      1'b1, 8'h00},
      '{5'd9,             32'd21400,      1'b1, 8'h00},
      '{5'd9,             32'd21500,      1'b1, 8'h13}, // digit 9
      '{5'd12,            32'd21600,      1'b0, 8'h00},
      '{5'd13,            32'd21700,      1'b0, 8'h00},
      '{5'd14,            32'd21800,      1'b0, 8'h00},
      '{5'd0,             32'd21900,      1'b0, 8'h00},
      '{5'd0,             32'd22000,      1'b0, 8'h00},
      '{CODE_READ_FAILED, 32'hFFFF_FFFF,  1'b1, 8'h00}
   };

   // Register settings and idle patterns; the last phase is randomized at run time.
   phase_type phase_plan [PHASE_N] = '{
      '{4'd2, 16'd1000,  16'd3000,  0,  0,  1'b1},
      '{4'd0, 16'd0,     16'd65535, 68, 0,  1'b0},
      '{4'd8, 16'd65535, 16'd0,     0,  68, 1'b0},
      '{4'd1, 16'd500,   16'd500,   16, 16, 1'b0},
      '{4'd3, 16'd3000,  16'd1000,  0,  0,  1'b0},
      '{4'd2, 16'd1000,  16'd3000,  16, 16, 1'b0}
   };

   initial begin
      forever #10 clock = ~clock;
   end

   // Computes the result of one classifier beat and advances the mirror state.
   function automatic rsp_type vote_filter_predict(input logic [CODE_W-1:0] code_raw,
                                                   input logic [TIME_W-1:0] now_ms);
      rsp_type            r;
      int                 code;
      logic [TIME_W-1:0]  dur;
      logic [DIGIT_W-1:0] old;
      logic [DIGIT_W-1:0] best;
      r    = '0;
      code = $signed(code_raw);
      if (code_raw == CODE_READ_FAILED) begin
         return r;
      end
      if (code_raw == CODE_CONTROL) begin
         if (!hold_running) begin
            hold_running = 1'b1;
            hold_t0      = now_ms;
         end
         return r;
      end
      // Close the hold, if any.
      dur = hold_running ? now_ms - hold_t0 : '0;
      if (dur > cfg_short_hold && dur < cfg_long_hold) begin
         r.backspace = 1'b1;
      end else if (dur > cfg_long_hold) begin
         r.long_hold = 1'b1;
      end
      hold_running = 1'b0;
      // Replace the oldest window slot.
      old = win_slots[win_pos];
      if (old < CLASS_N && class_votes[old] > 0) begin
         class_votes[old]--;
      end
      win_slots[win_pos] = EMPTY_ENTRY;
      if (code >= 0 && code < CLASS_N) begin
         win_slots[win_pos] = code_raw[DIGIT_W-1:0];
         class_votes[code_raw[DIGIT_W-1:0]]++;
      end
      win_pos = (win_pos == WIN_N - 1) ? 0 : win_pos + 1;
      // Majority with the lowest index winning ties.
      best = '0;
      for (int i = 1; i < CLASS_N; i++) begin
         if (class_votes[i] > class_votes[best]) begin
            best = DIGIT_W'(i);
         end
      end
      if (class_votes[best] > cfg_min_votes && best != last_digit) begin
         last_digit    = best;
         r.digit_valid = 1'b1;
         r.digit       = best;
      end
      return r;
   endfunction

   // Advances the running timestamp, now and then by a random jump.
   function automatic logic [TIME_W-1:0] next_now();
      if ($urandom_range(99) < 3) begin
         now_q = $urandom;
      end else begin
         now_q = now_q + $urandom_range(120);
      end
      return now_q;
   endfunction

   // Offers one request beat and records its expected result once accepted.
   task automatic send_beat(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now_ms,
                            input bit typed, input rsp_type typed_rsp);
      rsp_type want;
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, now_ms, code};
      do @(posedge clock); while (!req_tready);
      want = vote_filter_predict(code, now_ms);
      if (typed) begin
         want = typed_rsp;
      end
      results_due.push_back(want);
      beats_sent++;
      if (code != CODE_READ_FAILED) begin
         counted_beats++;
      end
   endtask

   // Writes one register, mirrors it and reads it back.
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_MIN_VOTES: begin
            cfg_min_votes = val[VOTE_W-1:0];
            mask          = (1 << VOTE_W) - 1;
         end
         REG_SHORT_HOLD: begin
            cfg_short_hold = val[LIMIT_W-1:0];
            mask           = (1 << LIMIT_W) - 1;
         end
         default: begin
            cfg_long_hold = val[LIMIT_W-1:0];
            mask          = (1 << LIMIT_W) - 1;
         end
      endcase
      // Read back in a second transfer.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) != (val & mask)) begin
         $error("register %0d: expected %0h, got %0h", idx, val & mask, csr_prdata & mask);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sends one random scenario: a vote run, a control hold or a single noise beat.
   task automatic send_random_scenario();
      int                pick;
      int                run_len;
      logic [CODE_W-1:0] cls;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] dur;
      pick = $urandom_range(99);
      if (pick < 45) begin
         cls     = CODE_W'($urandom_range(CLASS_N - 1));
         run_len = $urandom_range(1, 9);
         repeat (run_len) begin
            if ($urandom_range(99) < 15) begin
               send_beat($urandom_range(1) ? CODE_READ_FAILED : CODE_NO_CLASS, next_now(),
                         1'b0, '0);
            end
            send_beat(cls, next_now(), 1'b0, '0);
         end
      end else if (pick < 62) begin
         t0 = next_now();
         send_beat(CODE_CONTROL, t0, 1'b0, '0);
         repeat ($urandom_range(3)) begin
            send_beat($urandom_range(1) ? CODE_CONTROL : CODE_READ_FAILED,
                      t0 + $urandom_range(50), 1'b0, '0);
         end
         // Durations cluster around both limits.
         case ($urandom_range(7))
            0: dur = TIME_W'(cfg_short_hold) - 1;
            1: dur = TIME_W'(cfg_short_hold);
            2: dur = TIME_W'(cfg_short_hold) + 1;
            3: dur = TIME_W'(cfg_long_hold) - 1;
            4: dur = TIME_W'(cfg_long_hold);
            5: dur = TIME_W'(cfg_long_hold) + 1;
            6: dur = $urandom_range(70000);
            default: dur = $urandom;
         endcase
         now_q = t0 + dur;
         if ($urandom_range(99) < 80) begin
            cls = CODE_W'($urandom_range(CLASS_N - 1));
         end else begin
            cls = CODE_W'($urandom_range(31));
         end
         send_beat(cls, now_q, 1'b0, '0);
      end else begin
         send_beat(CODE_W'($urandom_range(31)), next_now(), 1'b0, '0);
      end
   endtask

   // Result side: random stalls, or a long hold-off when one is requested.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compares one result field and counts a mismatch.
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Checks every result beat against the oldest expectation; watchdog on idle cycles.
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (results_due.size() == 0) begin
            $error("result beat %0h with no result expected", got);
            mismatch_count++;
         end else begin
            want = results_due.pop_front();
            check_field("digit_valid", want.digit_valid, got.digit_valid);
            check_field("digit", want.digit, got.digit);
            check_field("backspace", want.backspace, got.backspace);
            check_field("long_hold", want.long_hold, got.long_hold);
            check_field("pad", want.pad, got.pad);
            digits_seen     += got.digit_valid;
            backspaces_seen += got.backspace;
            long_holds_seen += got.long_hold;
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", results_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Main sequence: reset, directed rows, then the random phases.
   initial begin : stimulus
      int target;
      for (int i = 0; i < WIN_N; i++) win_slots[i] = EMPTY_ENTRY;
      for (int i = 0; i < CLASS_N; i++) class_votes[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].code, directed_rows[i].now_ms,
                   directed_rows[i].typed, directed_rows[i].want);
      end
      req_tvalid <= 1'b0;

      phase_plan[PHASE_N-1].min_votes  = VOTE_W'($urandom_range(1, 3));
      phase_plan[PHASE_N-1].short_hold = LIMIT_W'($urandom_range(65535));
      phase_plan[PHASE_N-1].long_hold  = LIMIT_W'($urandom_range(65535));

      for (int p = 0; p < PHASE_N; p++) begin
         // Let the block drain before touching the registers.
         while (results_due.size() != 0) @(posedge clock);
         repeat (20) @(posedge clock);
         csr_write(REG_MIN_VOTES, CSR_DATA_W'(phase_plan[p].min_votes));
         csr_write(REG_SHORT_HOLD, CSR_DATA_W'(phase_plan[p].short_hold));
         csr_write(REG_LONG_HOLD, CSR_DATA_W'(phase_plan[p].long_hold));
         settings_used++;
         send_gap_pct  = phase_plan[p].gap_pct;
         rsp_stall_pct = phase_plan[p].stall_pct;
         if (phase_plan[p].hold_off) begin
            hold_off_cycles = HOLD_OFF_LEN;
         end
         target = counted_beats + PHASE_BEATS;
         while (counted_beats < target) send_random_scenario();
         req_tvalid <= 1'b0;
      end

      // Wait for the last results, then keep watching for stray beats.
      while (results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d request beats over %0d register settings; %0d results checked.",
               beats_sent, settings_used, results_seen);
      $display("Results carried %0d digits, %0d backspaces and %0d long holds.",
               digits_seen, backspaces_seen, long_holds_seen);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
